// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HFQ_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define HFQ_ASSERT_NXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define HFQ_ASSERT_IMP(label, a, b)
`define HFQ_ASSERT_NXT(label, a, b)
`endif
`endif

// ----- sv/hfq_pkg.sv -----
// ---------------------------------------------------------------------------
// Heightfield query package
// Shared constants and types of the heightfield height query block.
// ---------------------------------------------------------------------------
package hfq_pkg;

    localparam int DEF_MAX_GRID_X = 64;
    localparam int DEF_MAX_GRID_Y = 64;

    localparam int SAMPLE_W = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 104;
    localparam int OUT_DATA_W = 24;

    localparam logic [SAMPLE_W-1:0] H_BIAS = 24'h800000;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_X  = 2'd0,
        CFG_GRID_Y  = 2'd1,
        CFG_X_SCALE = 2'd2,
        CFG_D_SCALE = 2'd3
    } cfg_idx_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

// ----- sv/hfq_bank.sv -----
// ---------------------------------------------------------------------------
// Elevation bank
// One write port and one registered read port over a quarter of the grid.
// ---------------------------------------------------------------------------
module hfq_bank
    import hfq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  sample_t       wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output sample_t       rdata
);

    sample_t mem [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/heightfield_height_query.sv -----
// ---------------------------------------------------------------------------
// Heightfield height query
// Elevation grid store with triangle-interpolated height lookups.
// ---------------------------------------------------------------------------
// The block accepts one item per clock cycle when the output side does not
// stall, and returns the height of each query item as a result item. A
// write item (tuser opcode 0) stores one Q16.8 sample in the store and
// produces no result; a query item (opcode 1) scales its Q16.16 position by
// the Q8.16 scale registers, clamps it to the grid, picks the cell and the
// triangle whose diagonal alternates with the cell parity, and returns the
// barycentric height rounded to Q16.8. The store is split into four banks
// by the parity of the column and row, so the corners of any cell sit in
// different banks and each bank serves one read or one write per cycle;
// this is what holds the rate at one item per cycle. Writes take effect in
// item order with queries, at the third stage. Samples that were never
// written read as undefined values. The whole pipeline stalls together when
// a result waits and the output is not ready. The user must write configuration
// only while the block is idle; this is unenforced. Its channel is always ready.
module heightfield_height_query
    import hfq_pkg::*;
#(
    parameter int MAX_GRID_X = DEF_MAX_GRID_X,
    parameter int MAX_GRID_Y = DEF_MAX_GRID_Y
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input item: point_x, point_y, sample_height, pos_x, pos_depth, zero pad.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Input kind: opcode.
    input  logic [0:0]            s_tuser,
    // Result item: height.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    localparam int XW  = $clog2(MAX_GRID_X);
    localparam int YW  = $clog2(MAX_GRID_Y);
    localparam int NXW = $clog2(MAX_GRID_X + 1);
    localparam int NYW = $clog2(MAX_GRID_Y + 1);
    localparam int CXW = NXW + 16;
    localparam int CYW = NYW + 16;
    localparam int HX  = (MAX_GRID_X + 1) / 2;
    localparam int HY  = (MAX_GRID_Y + 1) / 2;
    localparam int BD  = HX * HY;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

    // Configuration registers.
    logic [6:0]  gpx_reg;
    logic [6:0]  gpy_reg;
    logic [23:0] xs_reg;
    logic [23:0] ds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpx_reg <= 7'd64;
            gpy_reg <= 7'd64;
            xs_reg  <= 24'd65536;
            ds_reg  <= 24'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_X:  gpx_reg <= cfg_data[6:0];
                CFG_GRID_Y:  gpy_reg <= cfg_data[6:0];
                CFG_X_SCALE: xs_reg  <= cfg_data;
                CFG_D_SCALE: ds_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Grid sizes saturated to the range the store supports.
    logic [NXW-1:0] nx;
    logic [NYW-1:0] ny;

    always_comb
    begin
        if (gpx_reg < 7'd2)
            nx = NXW'(2);
        else if (32'(gpx_reg) > MAX_GRID_X)
            nx = NXW'(MAX_GRID_X);
        else
            nx = NXW'(gpx_reg);
        if (gpy_reg < 7'd2)
            ny = NYW'(2);
        else if (32'(gpy_reg) > MAX_GRID_Y)
            ny = NYW'(MAX_GRID_Y);
        else
            ny = NYW'(gpy_reg);
    end

    // One enable moves every stage; a waiting result freezes the pipeline.
    logic    adv;
    logic    m_tvalid_reg;
    sample_t height_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = height_reg;

    // Stage 1: position times scale.
    logic        in_op;
    logic [5:0]  in_px;
    logic [5:0]  in_py;
    sample_t     in_h;
    logic [31:0] in_posx;
    logic [31:0] in_posd;
    logic [54:0] prodx_next;
    logic [54:0] prody_next;

    assign in_op   = s_tuser[0];
    assign in_px   = s_tdata[5:0];
    assign in_py   = s_tdata[11:6];
    assign in_h    = s_tdata[35:12];
    assign in_posx = s_tdata[67:36];
    assign in_posd = s_tdata[99:68];

    assign prodx_next = 55'(in_posx[30:0]) * 55'(xs_reg);
    assign prody_next = 55'(in_posd[30:0]) * 55'(ds_reg);

    logic        v1_reg;
    logic        op1_reg;
    logic [5:0]  px1_reg;
    logic [5:0]  py1_reg;
    sample_t     h1_reg;
    logic        negx1_reg;
    logic        negy1_reg;
    logic [54:0] prodx1_reg;
    logic [54:0] prody1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg    <= in_op;
            px1_reg    <= in_px;
            py1_reg    <= in_py;
            h1_reg     <= in_h;
            negx1_reg  <= in_posx[31];
            negy1_reg  <= in_posd[31];
            prodx1_reg <= prodx_next;
            prody1_reg <= prody_next;
        end
    end

    // Stage 2: clamp to the grid, split into cell and in-cell fraction.
    // At the far edge the cell is pulled back to the last cell with fraction 1.
    logic [CXW-1:0] limx;
    logic [CYW-1:0] limy;
    logic [CXW-1:0] cx;
    logic [CYW-1:0] cy;
    logic [NXW-1:0] cix;
    logic [NYW-1:0] ciy;
    logic           lastx;
    logic           lasty;
    logic [XW-1:0]  x0_next;
    logic [YW-1:0]  y0_next;
    logic [16:0]    fx_next;
    logic [16:0]    fy_next;

    always_comb
    begin
        limx = {nx - NXW'(1), 16'h0};
        limy = {ny - NYW'(1), 16'h0};
        if (negx1_reg)
            cx = '0;
        else if (prodx1_reg[54:16] > 39'(limx))
            cx = limx;
        else
            cx = CXW'(prodx1_reg[54:16]);
        if (negy1_reg)
            cy = '0;
        else if (prody1_reg[54:16] > 39'(limy))
            cy = limy;
        else
            cy = CYW'(prody1_reg[54:16]);
        cix   = cx[CXW-1:16];
        ciy   = cy[CYW-1:16];
        lastx = cix > (nx - NXW'(2));
        lasty = ciy > (ny - NYW'(2));
        x0_next = lastx ? XW'(nx - NXW'(2)) : XW'(cix);
        y0_next = lasty ? YW'(ny - NYW'(2)) : YW'(ciy);
        fx_next = {lastx, cx[15:0]};
        fy_next = {lasty, cy[15:0]};
    end

    logic          v2_reg;
    logic          op2_reg;
    logic [5:0]    px2_reg;
    logic [5:0]    py2_reg;
    sample_t       h2_reg;
    logic [XW-1:0] x02_reg;
    logic [YW-1:0] y02_reg;
    logic [16:0]   fx2_reg;
    logic [16:0]   fy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg <= op1_reg;
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            h2_reg  <= h1_reg;
            x02_reg <= x0_next;
            y02_reg <= y0_next;
            fx2_reg <= fx_next;
            fy2_reg <= fy_next;
        end
    end

    // Stage 3: bank access and triangle weights.
    logic           wr_ok;
    logic [BAW-1:0] wr_addr;
    sample_t        wr_data;
    logic           rd_en;
    sample_t        rd_data [4];

    assign wr_ok   = adv && v2_reg && (op2_reg == OP_WRITE)
                     && (32'(px2_reg) < MAX_GRID_X) && (32'(py2_reg) < MAX_GRID_Y);
    assign wr_addr = BAW'(px2_reg >> 1) + BAW'(HX) * BAW'(py2_reg >> 1);
    assign wr_data = h2_reg ^ H_BIAS;
    assign rd_en   = adv && v2_reg && (op2_reg == OP_QUERY);

    genvar b;
    generate
        for (b = 0; b < 4; b++)
        begin : g_bank
            localparam bit BX = (b % 2) == 1;
            localparam bit BY = (b / 2) == 1;
            logic [XW-1:0]  xb;
            logic [YW-1:0]  yb;
            logic [BAW-1:0] raddr;
            logic           we;

            // The corner of this bank's parity is either x0 or x0 + 1.
            assign xb    = (x02_reg[0] == BX) ? x02_reg : x02_reg + XW'(1);
            assign yb    = (y02_reg[0] == BY) ? y02_reg : y02_reg + YW'(1);
            assign raddr = BAW'(xb >> 1) + BAW'(HX) * BAW'(yb >> 1);
            assign we    = wr_ok && (px2_reg[0] == BX) && (py2_reg[0] == BY);

            hfq_bank #(
                .DEPTH(BD),
                .AW(BAW)
            ) u_bank (
                .clk(clk),
                .we(we),
                .waddr(wr_addr),
                .wdata(wr_data),
                .re(rd_en),
                .raddr(raddr),
                .rdata(rd_data[b])
            );
        end
    endgenerate

    logic [16:0] w00_next;
    logic [16:0] w10_next;
    logic [16:0] w01_next;
    logic [16:0] w11_next;
    logic [17:0] fsum;

    always_comb
    begin
        fsum     = 18'(fx2_reg) + 18'(fy2_reg);
        w00_next = '0;
        w10_next = '0;
        w01_next = '0;
        w11_next = '0;
        if ((x02_reg[0] ^ y02_reg[0]) == 1'b0)
        begin
            // Even cell: diagonal from (x0,y0) to (x1,y1).
            if (fy2_reg < fx2_reg)
            begin
                w00_next = ONE_Q16 - fx2_reg;
                w10_next = fx2_reg - fy2_reg;
                w11_next = fy2_reg;
            end
            else
            begin
                w11_next = fx2_reg;
                w01_next = fy2_reg - fx2_reg;
                w00_next = ONE_Q16 - fy2_reg;
            end
        end
        else
        begin
            // Odd cell: diagonal from (x1,y0) to (x0,y1).
            if (fsum < 18'(ONE_Q16))
            begin
                w00_next = 17'(18'(ONE_Q16) - fsum);
                w10_next = fx2_reg;
                w01_next = fy2_reg;
            end
            else
            begin
                w11_next = 17'(fsum - 18'(ONE_Q16));
                w01_next = ONE_Q16 - fx2_reg;
                w10_next = ONE_Q16 - fy2_reg;
            end
        end
    end

    logic        v3_reg;
    logic        x0p3_reg;
    logic        y0p3_reg;
    logic [16:0] w00_3_reg;
    logic [16:0] w10_3_reg;
    logic [16:0] w01_3_reg;
    logic [16:0] w11_3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg && (op2_reg == OP_QUERY);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0p3_reg  <= x02_reg[0];
            y0p3_reg  <= y02_reg[0];
            w00_3_reg <= w00_next;
            w10_3_reg <= w10_next;
            w01_3_reg <= w01_next;
            w11_3_reg <= w11_next;
        end
    end

    // Stage 4: weight the four corner samples.
    sample_t     h00;
    sample_t     h10;
    sample_t     h01;
    sample_t     h11;
    logic [40:0] p00_reg;
    logic [40:0] p10_reg;
    logic [40:0] p01_reg;
    logic [40:0] p11_reg;
    logic        v4_reg;

    assign h00 = rd_data[{y0p3_reg, x0p3_reg}];
    assign h10 = rd_data[{y0p3_reg, !x0p3_reg}];
    assign h01 = rd_data[{!y0p3_reg, x0p3_reg}];
    assign h11 = rd_data[{!y0p3_reg, !x0p3_reg}];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p00_reg <= 41'(w00_3_reg) * 41'(h00);
            p10_reg <= 41'(w10_3_reg) * 41'(h10);
            p01_reg <= 41'(w01_3_reg) * 41'(h01);
            p11_reg <= 41'(w11_3_reg) * 41'(h11);
        end
    end

    // Stage 5: sum, round half up, back to signed Q16.8.
    logic [42:0] acc_next;
    sample_t     height_next;

    assign acc_next = 43'(p00_reg) + 43'(p10_reg) + 43'(p01_reg) + 43'(p11_reg)
                      + 43'(ONE_Q16 >> 1);
    assign height_next = acc_next[39:16] ^ H_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            height_reg <= height_next;
        end
    end

    // Checks on the pipeline.
    `HFQ_ASSERT_NXT(a_stall_holds, !s_tready, $stable({v1_reg, v2_reg, v3_reg, v4_reg}))
    `HFQ_ASSERT_NXT(a_result_moves, v4_reg && s_tready, m_tvalid)
    `HFQ_ASSERT_IMP(a_weights_one, v3_reg,
        (19'(w00_3_reg) + 19'(w10_3_reg) + 19'(w01_3_reg) + 19'(w11_3_reg)) == 19'(ONE_Q16))

endmodule
